@@ rtl/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: fragment reassembly tracker shared types
// Transfer payloads, slot key, scan flags and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

	localparam int KEY_W = 112;
	localparam int AGE_W = 32;

	localparam logic [2:0] ST_WAIT  = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_DUP   = 3'd3;
	localparam logic [2:0] ST_LAST2 = 3'd4;

	typedef struct packed {
		logic [15:0] msg_id;
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
		logic [7:0]  fragment_number;
		logic        last_flag;
	} frt_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] slot_index;
		logic       evicted;
		logic [4:0] final_fragment;
	} frt_out_t;

	typedef struct packed {
		logic [15:0] msg_id;
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
	} frt_key_t;

	typedef struct packed {
		logic match_found;
		logic free_found;
	} frt_scan_flags_t;

endpackage

`default_nettype wire

@@ rtl/frt_slot_mem.sv @@
// ----------------------------------------------------------------------------
// frt_slot_mem: slot table storage
// One write port and one registered read port over the slot entries.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_slot_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/frt_scan.sv @@
// ----------------------------------------------------------------------------
// frt_scan: slot scan unit
// Compares one slot per cycle against the fragment key and tracks the first
// match, the first free slot and the oldest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_scan
	import frt_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int MAX_FRAGS = 26,
	localparam int IDX_W = $clog2(SLOTS),
	localparam int LI_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 cmp_vld,
	input  wire logic [IDX_W-1:0]     cmp_idx,
	input  wire frt_key_t             key,
	input  wire logic                 slot_vld,
	input  wire frt_key_t             slot_key,
	input  wire logic [MAX_FRAGS-1:0] slot_seen,
	input  wire logic                 slot_has_last,
	input  wire logic [LI_W-1:0]      slot_last,
	input  wire logic [AGE_W-1:0]     slot_age,
	output frt_scan_flags_t           flags,
	output logic [IDX_W-1:0]          match_idx,
	output logic [MAX_FRAGS-1:0]      match_seen,
	output logic                      match_has_last,
	output logic [LI_W-1:0]           match_last,
	output logic [IDX_W-1:0]          free_idx,
	output logic [IDX_W-1:0]          best_idx
);

	frt_scan_flags_t  flags_q;
	logic [AGE_W-1:0] best_age_q;
	logic             hit;
	logic             older;

	assign hit   = slot_vld && (slot_key == key);
	assign older = (cmp_idx == '0) || (slot_age < best_age_q);
	assign flags = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (start) begin
			flags_q <= '0;
		end else if (cmp_vld) begin
			if (hit) begin
				flags_q.match_found <= 1'b1;
			end
			if (!slot_vld) begin
				flags_q.free_found <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld) begin
			if (hit && !flags_q.match_found) begin
				match_idx      <= cmp_idx;
				match_seen     <= slot_seen;
				match_has_last <= slot_has_last;
				match_last     <= slot_last;
			end
			if (!slot_vld && !flags_q.free_found) begin
				free_idx <= cmp_idx;
			end
			if (older) begin
				best_age_q <= slot_age;
				best_idx   <= cmp_idx;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/fragment_reassembly_tracker_top.sv @@
// The slot scan reads one table entry per cycle through the single memory read
// port. Not ready while a fragment is in flight; a finished result may wait in
// the output register while the next fragment is taken.
// Reset clears all slot valid bits and the age counter; no clearing pass.
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_top: fragment reassembly slot tracker
// Matches fragment headers to reassembly slots, records fragments, evicts the
// oldest slot when full and reports completion.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker_top
	import frt_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int MAX_FRAGS = 26
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     frag_valid,
	output logic          frag_ready,
	input  wire frt_in_t  frag,
	output logic          res_valid,
	input  wire logic     res_ready,
	output frt_out_t      res
);

	localparam int IDX_W    = $clog2(SLOTS);
	localparam int LI_W     = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
	localparam int SEEN_LSB = LI_W + 1;
	localparam int KEY_LSB  = SEEN_LSB + MAX_FRAGS;
	localparam int AGE_LSB  = KEY_LSB + KEY_W;
	localparam int ENT_W    = AGE_LSB + AGE_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_LAST   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     issue_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	frt_in_t              item_q;
	frt_key_t             key;
	logic [SLOTS-1:0]     valid_q;
	logic [AGE_W-1:0]     age_q;

	logic [ENT_W-1:0]     rd_word;
	logic [ENT_W-1:0]     wr_word;
	frt_key_t             rd_key;

	frt_scan_flags_t      flags;
	logic [IDX_W-1:0]     match_idx;
	logic [MAX_FRAGS-1:0] match_seen;
	logic                 match_has_last;
	logic [LI_W-1:0]      match_last;
	logic [IDX_W-1:0]     free_idx;
	logic [IDX_W-1:0]     best_idx;

	logic                 rng;
	logic [MAX_FRAGS-1:0] bit_oh;
	logic [LI_W-1:0]      frag_li;
	logic [2:0]           rej_d;
	logic                 wr_en_d;
	logic [IDX_W-1:0]     slot_d;
	logic                 ev_d;
	logic [MAX_FRAGS-1:0] seen_d;
	logic                 has_last_d;
	logic [LI_W-1:0]      last_d;

	logic [2:0]           rej_q;
	logic                 wr_en_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 ev_q;
	logic [MAX_FRAGS-1:0] seen_q;
	logic                 has_last_q;
	logic [LI_W-1:0]      last_q;

	logic [MAX_FRAGS-1:0] need;
	logic                 complete;
	logic                 out_free;
	logic                 fire;
	logic                 start;
	frt_out_t             res_d;

	assign frag_ready = (state_q == S_IDLE);
	assign start      = frag_valid && frag_ready;
	assign out_free   = !res_valid || res_ready;
	assign fire       = (state_q == S_COMMIT) && out_free;

	assign key.msg_id     = item_q.msg_id;
	assign key.source_mac = item_q.source_mac;
	assign key.dest_mac   = item_q.dest_mac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issue_q    <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					issue_q <= '0;
					if (start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_LAST;
					end else begin
						issue_q <= issue_q + 1'b1;
					end
				end
				S_LAST:   state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_q;
		if (start) begin
			item_q <= frag;
		end
	end

	frt_slot_mem #(
		.DEPTH (SLOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (fire && wr_en_q),
		.waddr (slot_q),
		.wdata (wr_word),
		.raddr (issue_q),
		.rdata (rd_word)
	);

	assign rd_key = frt_key_t'(rd_word[AGE_LSB-1:KEY_LSB]);

	frt_scan #(
		.SLOTS     (SLOTS),
		.MAX_FRAGS (MAX_FRAGS)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.cmp_vld        (cmp_vld_s1),
		.cmp_idx        (cmp_idx_s1),
		.key            (key),
		.slot_vld       (valid_q[cmp_idx_s1]),
		.slot_key       (rd_key),
		.slot_seen      (rd_word[KEY_LSB-1:SEEN_LSB]),
		.slot_has_last  (rd_word[LI_W]),
		.slot_last      (rd_word[LI_W-1:0]),
		.slot_age       (rd_word[ENT_W-1:AGE_LSB]),
		.flags          (flags),
		.match_idx      (match_idx),
		.match_seen     (match_seen),
		.match_has_last (match_has_last),
		.match_last     (match_last),
		.free_idx       (free_idx),
		.best_idx       (best_idx)
	);

	assign rng     = item_q.fragment_number >= 8'(MAX_FRAGS);
	assign bit_oh  = MAX_FRAGS'(1) << item_q.fragment_number;
	assign frag_li = item_q.fragment_number[LI_W-1:0];

	always_comb begin
		rej_d      = ST_WAIT;
		wr_en_d    = 1'b0;
		slot_d     = '0;
		ev_d       = 1'b0;
		seen_d     = bit_oh;
		has_last_d = item_q.last_flag;
		last_d     = item_q.last_flag ? frag_li : '0;
		if (rng) begin
			rej_d  = ST_RANGE;
			slot_d = flags.match_found ? match_idx : '0;
		end else if (flags.match_found) begin
			slot_d = match_idx;
			if ((match_seen & bit_oh) != '0) begin
				rej_d = ST_DUP;
			end else if (item_q.last_flag && match_has_last) begin
				rej_d = ST_LAST2;
			end else begin
				wr_en_d    = 1'b1;
				seen_d     = match_seen | bit_oh;
				has_last_d = match_has_last | item_q.last_flag;
				last_d     = item_q.last_flag ? frag_li : match_last;
			end
		end else begin
			wr_en_d = 1'b1;
			slot_d  = flags.free_found ? free_idx : best_idx;
			ev_d    = !flags.free_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else if (state_q == S_DECIDE) begin
			wr_en_q <= wr_en_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			rej_q      <= rej_d;
			slot_q     <= slot_d;
			ev_q       <= ev_d;
			seen_q     <= seen_d;
			has_last_q <= has_last_d;
			last_q     <= last_d;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAGS; i++) begin
			need[i] = (last_q >= LI_W'(i));
		end
	end

	assign complete = has_last_q && ((seen_q & need) == need);
	assign wr_word  = {age_q, key, seen_q, has_last_q, last_q};

	always_comb begin
		res_d.slot_index     = 3'(slot_q);
		res_d.evicted        = wr_en_q && ev_q;
		res_d.status         = rej_q;
		res_d.final_fragment = '0;
		if (wr_en_q) begin
			res_d.status = complete ? ST_DONE : ST_WAIT;
			if (complete) begin
				res_d.final_fragment = 5'(last_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			age_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (fire && wr_en_q) begin
				valid_q[slot_q] <= !complete;
				age_q           <= age_q + 1'b1;
			end
			if (fire) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/frt_checker.sv @@
// ----------------------------------------------------------------------------
// frt_checker: port-level checks for the fragment reassembly tracker
// Watches the fragment and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_checker
	import frt_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     frag_valid,
	input wire logic     frag_ready,
	input wire frt_in_t  frag,
	input wire logic     res_valid,
	input wire logic     res_ready,
	input wire frt_out_t res
);

	a_frag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frag_valid && !frag_ready |=> frag_valid && $stable(frag))
		else $error("fragment changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		frag_valid && frag_ready |=> !frag_ready)
		else $error("ready right after a fragment transfer");

	a_fin_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_DONE |-> res.final_fragment == 5'd0)
		else $error("final fragment set on a result that is not complete");

	a_no_evict_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_RANGE || res.status == ST_DUP ||
			res.status == ST_LAST2) |-> !res.evicted)
		else $error("eviction on a rejected fragment");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.frag_valid (frag_valid),
	.frag_ready (frag_ready),
	.frag       (frag),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.res        (res)
);

`default_nettype wire

@@ test/frt_checker.sv @@
// ----------------------------------------------------------------------------
// frt_scoreboard: fragment reassembly tracker result checker
// Watches both transfer channels, keeps its own slot table to predict the
// result of every accepted fragment, and compares each result field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module frt_scoreboard
	import frt_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int MAX_FRAGS = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frag_valid,
	input  logic        frag_ready,
	input  frt_in_t     frag,
	input  logic        res_valid,
	input  logic        res_ready,
	input  frt_out_t    res,
	output int          errors,
	output int          waiting
);

	logic        tbl_valid[SLOTS];
	frt_key_t    tbl_key[SLOTS];
	logic [63:0] tbl_seen[SLOTS];
	logic [7:0]  tbl_last[SLOTS];
	logic        tbl_has_last[SLOTS];
	logic [31:0] tbl_age[SLOTS];
	logic [31:0] age_ctr;

	frt_out_t    result_q[$];
	int          err_count;

	task report(input string what, input int want, input int got);
		$display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
		err_count++;
	endtask

	task track_fragment(input frt_in_t f, output frt_out_t r);
		frt_key_t    key;
		int          hit;
		int          best;
		logic [63:0] bit_m;
		logic [63:0] need;
		logic        ev;
		logic        rejected;
		key = {f.msg_id, f.source_mac, f.dest_mac};
		hit = SLOTS;
		ev = 1'b0;
		rejected = 1'b0;
		r = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (tbl_valid[k] && tbl_key[k] == key)
				hit = k;
		end
		if (f.fragment_number >= MAX_FRAGS) begin
			r.status = ST_RANGE;
			r.slot_index = (hit < SLOTS) ? hit[2:0] : 3'd0;
			rejected = 1'b1;
		end else begin
			bit_m = 64'd1 << f.fragment_number;
			if (hit < SLOTS) begin
				if ((tbl_seen[hit] & bit_m) != 0) begin
					r.status = ST_DUP;
					r.slot_index = hit[2:0];
					rejected = 1'b1;
				end else if (f.last_flag && tbl_has_last[hit]) begin
					r.status = ST_LAST2;
					r.slot_index = hit[2:0];
					rejected = 1'b1;
				end else begin
					tbl_seen[hit] = tbl_seen[hit] | bit_m;
					if (f.last_flag) begin
						tbl_has_last[hit] = 1'b1;
						tbl_last[hit] = f.fragment_number;
					end
				end
			end else begin
				for (int k = SLOTS - 1; k >= 0; k--) begin
					if (!tbl_valid[k])
						hit = k;
				end
				if (hit >= SLOTS) begin
					best = 0;
					for (int k = 1; k < SLOTS; k++) begin
						if (tbl_age[k] < tbl_age[best])
							best = k;
					end
					hit = best;
					ev = 1'b1;
				end
				tbl_valid[hit] = 1'b1;
				tbl_key[hit] = key;
				tbl_seen[hit] = bit_m;
				tbl_has_last[hit] = f.last_flag;
				tbl_last[hit] = f.last_flag ? f.fragment_number : 8'd0;
			end
		end
		if (!rejected) begin
			tbl_age[hit] = age_ctr;
			age_ctr = age_ctr + 32'd1;
			r.slot_index = hit[2:0];
			r.evicted = ev;
			r.status = ST_WAIT;
			if (tbl_has_last[hit]) begin
				need = (64'd2 << tbl_last[hit]) - 64'd1;
				if ((tbl_seen[hit] & need) == need) begin
					tbl_valid[hit] = 1'b0;
					r.status = ST_DONE;
					r.final_fragment = tbl_last[hit][4:0];
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frt_out_t want;
		frt_out_t got;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				tbl_valid[k] = 1'b0;
				tbl_age[k] = '0;
				tbl_seen[k] = '0;
				tbl_has_last[k] = 1'b0;
				tbl_last[k] = '0;
				tbl_key[k] = '0;
			end
			age_ctr = '0;
			result_q.delete();
			err_count = 0;
			errors <= 0;
			waiting <= 0;
		end else begin
			if (frag_valid && frag_ready) begin
				track_fragment(frag, want);
				result_q.push_back(want);
			end
			if (res_valid && res_ready) begin
				got = res;
				if (result_q.size() == 0) begin
					report("result with no fragment outstanding, status", -1,
						int'(got.status));
				end else begin
					want = result_q.pop_front();
					if (got.status !== want.status)
						report("status", int'(want.status), int'(got.status));
					if (got.slot_index !== want.slot_index)
						report("slot_index", int'(want.slot_index), int'(got.slot_index));
					if (got.evicted !== want.evicted)
						report("evicted", int'(want.evicted), int'(got.evicted));
					if (got.final_fragment !== want.final_fragment)
						report("final_fragment", int'(want.final_fragment),
							int'(got.final_fragment));
				end
			end
			errors <= err_count;
			waiting <= result_q.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: fragment reassembly tracker testbench
// Drives directed fragment headers covering completion, range, duplicate,
// second-last and eviction cases, then randomized interleaved messages with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import frt_pkg::*;

	localparam int SLOTS = 8;
	localparam int MAX_FRAGS = 26;
	localparam int POOL = 12;
	localparam int RANDOM_ITEMS = 1430;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);

	logic     clk;
	logic     arst_n;
	logic     frag_valid;
	logic     frag_ready;
	frt_in_t  frag;
	logic     res_valid;
	logic     res_ready;
	frt_out_t res;
	int       check_errors;
	int       check_waiting;

	frt_key_t    msg_key[POOL];
	int          msg_last[POOL];
	logic [25:0] msg_todo[POOL];
	logic [25:0] msg_sent[POOL];

	int          burst_left;
	bit          tx_gaps;
	int          cycle_count;
	int          rx_mode;
	int          rx_left;
	int          rx_period;
	int          rx_duty;
	int          rx_phase;

	fragment_reassembly_tracker_top #(
		.SLOTS(SLOTS),
		.MAX_FRAGS(MAX_FRAGS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frag_valid(frag_valid),
		.frag_ready(frag_ready),
		.frag(frag),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	frt_scoreboard #(
		.SLOTS(SLOTS),
		.MAX_FRAGS(MAX_FRAGS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.frag_valid(frag_valid),
		.frag_ready(frag_ready),
		.frag(frag),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.errors(check_errors),
		.waiting(check_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls in changing patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
			rx_period = $urandom_range(2, 24);
			rx_duty = $urandom_range(1, rx_period - 1);
			rx_phase = 0;
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			2: res_ready <= ($urandom_range(0, 3) == 0);
			default: res_ready <= (rx_phase < rx_duty);
		endcase
		rx_phase = (rx_phase + 1) % rx_period;
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	function automatic frt_in_t make_frag(logic [15:0] mid, logic [47:0] src,
			logic [47:0] dst, logic [7:0] num, logic last);
		frt_in_t f;
		f.msg_id = mid;
		f.source_mac = src;
		f.dest_mac = dst;
		f.fragment_number = num;
		f.last_flag = last;
		return f;
	endfunction

	function automatic int pick_bit(logic [25:0] m);
		int start;
		int j;
		start = $urandom_range(0, 25);
		for (int i = 0; i < 26; i++) begin
			j = (start + i) % 26;
			if (m[j])
				return j;
		end
		return start;
	endfunction

	task automatic push_fragment(input frt_in_t item);
		int gap_len;
		frag <= item;
		frag_valid <= 1'b1;
		@(posedge clk);
		while (!frag_ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap_len = tx_gaps ? $urandom_range(1, 15) : 0;
			if (gap_len > 0) begin
				frag_valid <= 1'b0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	task automatic start_message(input int idx);
		int r;
		int other;
		r = $urandom_range(0, 99);
		other = $urandom_range(0, POOL - 1);
		msg_key[idx] = {16'($urandom()), rand_mac(), rand_mac()};
		if (r >= 60 && r < 75)
			msg_key[idx] = {16'($urandom()), msg_key[other].source_mac,
				msg_key[other].dest_mac};
		else if (r >= 75 && r < 90)
			msg_key[idx] = {msg_key[other].msg_id, rand_mac(), msg_key[other].dest_mac};
		else if (r >= 90)
			msg_key[idx] = {msg_key[other].msg_id, msg_key[other].source_mac, rand_mac()};
		r = $urandom_range(0, 99);
		if (r < 50)
			msg_last[idx] = $urandom_range(0, 3);
		else if (r < 85)
			msg_last[idx] = $urandom_range(4, 10);
		else
			msg_last[idx] = $urandom_range(11, 25);
		msg_todo[idx] = (26'd2 << msg_last[idx]) - 26'd1;
		if (msg_last[idx] < 25 && $urandom_range(0, 9) < 3)
			msg_todo[idx][$urandom_range(msg_last[idx] + 1, 25)] = 1'b1;
		msg_sent[idx] = '0;
	endtask

	task automatic directed_part();
		frt_in_t f;
		push_fragment(make_frag('0, '0, '0, 8'd0, 1'b1));
		push_fragment(make_frag('1, '1, '1, 8'd255, 1'b1));
		push_fragment(make_frag('1, '1, '1, 8'd25, 1'b1));
		push_fragment(make_frag('1, '1, '1, 8'd25, 1'b0));
		push_fragment(make_frag('1, '1, '1, 8'd3, 1'b1));
		push_fragment(make_frag('1, '1, '1, 8'd26, 1'b0));
		push_fragment(make_frag(16'h1234, 48'h0a0b0c0d0e0f, 48'h1, 8'd2, 1'b0));
		push_fragment(make_frag(16'h1234, 48'h0a0b0c0d0e0f, 48'h1, 8'd1, 1'b1));
		push_fragment(make_frag(16'h1234, 48'h0a0b0c0d0e0f, 48'h1, 8'd5, 1'b0));
		push_fragment(make_frag(16'h1234, 48'h0a0b0c0d0e0f, 48'h1, 8'd0, 1'b0));
		// fill the table, then force evictions of the oldest slots
		for (int i = 0; i < 9; i++) begin
			f = make_frag(16'(16'h0100 + i), 48'h5555aaaa5555, 48'h2, 8'd1, 1'b0);
			push_fragment(f);
		end
		push_fragment(make_frag(16'h0103, 48'h5555aaaa5555, 48'h2, 8'd0, 1'b1));
		push_fragment(make_frag(16'h0101, 48'h5555aaaa5555, 48'h2, 8'd0, 1'b1));
	endtask

	task automatic random_part();
		frt_in_t f;
		int      active_n;
		int      idx;
		int      r;
		int      num;
		active_n = 4;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				active_n = $urandom_range(2, POOL);
				tx_gaps = ($urandom_range(0, 3) != 0);
			end
			idx = $urandom_range(0, active_n - 1);
			r = $urandom_range(0, 99);
			if (r < 78) begin
				num = pick_bit(msg_todo[idx]);
				msg_todo[idx][num] = 1'b0;
				msg_sent[idx][num] = 1'b1;
				f = {msg_key[idx], 8'(num), 1'(num == msg_last[idx])};
				if (msg_todo[idx] == '0)
					start_message(idx);
			end else if (r < 84) begin
				num = (msg_sent[idx] != '0) ? pick_bit(msg_sent[idx]) : $urandom_range(0, 25);
				f = {msg_key[idx], 8'(num), 1'($urandom_range(0, 1))};
			end else if (r < 89) begin
				f = {msg_key[idx], 8'($urandom_range(0, 25)), 1'b1};
			end else if (r < 94) begin
				f = {msg_key[idx], 8'($urandom_range(MAX_FRAGS, 255)), 1'($urandom_range(0, 1))};
				if ($urandom_range(0, 1))
					f = make_frag(16'($urandom()), rand_mac(), rand_mac(),
						f.fragment_number, f.last_flag);
			end else begin
				f = make_frag(16'($urandom()), rand_mac(), rand_mac(),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			push_fragment(f);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		frag_valid = 1'b0;
		frag = '0;
		res_ready = 1'b0;
		cycle_count = 0;
		rx_left = 0;
		burst_left = 0;
		tx_gaps = 1'b1;
		for (int i = 0; i < POOL; i++)
			msg_key[i] = '0;
		for (int i = 0; i < POOL; i++)
			start_message(i);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_part();
		random_part();
		frag_valid <= 1'b0;
		while (check_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (check_errors == 0 && check_waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
